// ===== hdl/digital_pot_step_controller_macros.svh =====
// ----------------------------------------------------------------------------
// digital pot step controller assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef DIGITAL_POT_STEP_CONTROLLER_MACROS_SVH
`define DIGITAL_POT_STEP_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DPSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpsc same-cycle property failed");

// next-cycle implication, disabled during reset
`define DPSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpsc next-cycle property failed");

`endif

// ===== hdl/dpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpsc_pkg
// types and codes shared by the digital pot step controller
// ----------------------------------------------------------------------------
`default_nettype none

package dpsc_pkg;

   localparam logic [2:0] FN_TICK  = 3'd0;
   localparam logic [2:0] FN_GOTO  = 3'd1;
   localparam logic [2:0] FN_DELTA = 3'd2;
   localparam logic [2:0] FN_RESET = 3'd3;
   localparam logic [2:0] FN_MAX   = 3'd4;

   localparam logic [2:0] CSR_PULSE_TICKS  = 3'd0;
   localparam logic [2:0] CSR_EXTRA_TOP    = 3'd1;
   localparam logic [2:0] CSR_EXTRA_BOTTOM = 3'd2;
   localparam logic [2:0] CSR_INVERT_DIR   = 3'd3;
   localparam logic [2:0] CSR_RISING_ONLY  = 3'd4;

   typedef struct packed {
      logic [15:0] pulse_ticks;
      logic [3:0]  extra_pulses_top;
      logic [3:0]  extra_pulses_bottom;
      logic        invert_direction;
      logic        rising_edge_only;
   } cfg_type;

   typedef struct packed {
      logic [2:0]        func;
      logic [6:0]        target;
      logic signed [8:0] delta;
   } item_type;

   typedef struct packed {
      logic       chip_select_n;
      logic       inc_level;
      logic       up_down_level;
      logic       busy_res;
      logic [6:0] position;
      logic       at_bottom_anchor;
      logic       at_top_anchor;
      logic       rejected;
      logic       done_res;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/dpsc_core.sv =====
// ----------------------------------------------------------------------------
// dpsc_core
// wiper tracking and pin sequencing state, one transaction per enable
// ----------------------------------------------------------------------------
`default_nettype none

module dpsc_core #(
   parameter int TOP_STEP = 99
) (
   input  wire                  clock,
   input  wire                  reset,
   input  dpsc_pkg::cfg_type    cfg,
   input  wire                  step_en,
   input  dpsc_pkg::item_type   item,
   output dpsc_pkg::result_type result
);
   import dpsc_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_IDLELOW, PH_ACTIVE} phase_type;
   typedef enum logic [1:0] {MD_GOTO, MD_DELTA, MD_RDOWN, MD_EXTRA} mode_type;
   typedef enum logic [1:0] {SB_PREP, SB_HIGH, SB_LOW} sub_type;

   localparam logic [6:0] TOP7 = 7'(TOP_STEP);
   localparam logic [8:0] RDOWN_TAPS = 9'(TOP_STEP + 1);

   logic [6:0]  wiper_ff, wiper_in;
   logic        anchor_bottom_ff, anchor_bottom_in;
   logic        anchor_top_ff, anchor_top_in;
   logic        inc_high_ff, inc_high_in;
   logic [8:0]  taps_left_ff, taps_left_in;
   phase_type   phase_ff, phase_in;
   mode_type    mode_ff, mode_in;
   sub_type     sub_ff, sub_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [6:0]  goal_step_ff, goal_step_in;
   logic        going_up_ff, going_up_in;

   logic        is_cmd;
   logic        finished;
   logic        rej;
   logic        do_final;
   logic [6:0]  final_g;
   logic        do_start;
   mode_type    start_mode;
   logic [6:0]  g;
   logic [8:0]  t;
   logic [3:0]  n;
   logic [15:0] pt;
   logic        cs;
   logic        inc;

   assign is_cmd = (item.func inside {[FN_GOTO:FN_MAX]});
   assign pt     = (cfg.pulse_ticks == 16'd0) ? 16'd1 : cfg.pulse_ticks;

   always_comb begin
      wiper_in         = wiper_ff;
      anchor_bottom_in = anchor_bottom_ff;
      anchor_top_in    = anchor_top_ff;
      inc_high_in      = inc_high_ff;
      taps_left_in     = taps_left_ff;
      phase_in         = phase_ff;
      mode_in          = mode_ff;
      sub_in           = sub_ff;
      tick_count_in    = tick_count_ff;
      goal_step_in     = goal_step_ff;
      going_up_in      = going_up_ff;
      finished         = 1'b0;
      rej              = 1'b0;
      do_final         = 1'b0;
      final_g          = 7'd0;
      do_start         = 1'b0;
      start_mode       = MD_GOTO;
      g                = 7'd0;
      t                = 9'd0;
      n                = 4'd0;

      if (phase_ff == PH_IDLE && is_cmd) begin
         case (item.func)
            FN_DELTA: begin
               if (item.delta == 9'sd0) begin
                  phase_in      = PH_IDLE;
                  tick_count_in = 16'd0;
                  finished      = 1'b1;
               end else begin
                  going_up_in  = ~item.delta[8];
                  taps_left_in = item.delta[8] ? 9'(~item.delta + 9'd1) : item.delta;
                  do_start     = 1'b1;
                  start_mode   = MD_DELTA;
               end
            end
            FN_RESET: begin
               going_up_in  = 1'b0;
               taps_left_in = RDOWN_TAPS;
               do_start     = 1'b1;
               start_mode   = MD_RDOWN;
            end
            default: begin
               if (item.func == FN_MAX) begin
                  g = TOP7;
               end else begin
                  g = (item.target > TOP7) ? TOP7 : item.target;
               end
               goal_step_in = g;
               if (g == wiper_ff) begin
                  if ((g == 7'd0 && !anchor_bottom_ff) || (g == TOP7 && !anchor_top_ff)) begin
                     do_final = 1'b1;
                     final_g  = g;
                  end else begin
                     phase_in      = PH_IDLE;
                     tick_count_in = 16'd0;
                     finished      = 1'b1;
                  end
               end else begin
                  going_up_in = (wiper_ff < g);
                  do_start    = 1'b1;
                  start_mode  = MD_GOTO;
               end
            end
         endcase
      end else begin
         rej = is_cmd;
         if (phase_ff != PH_IDLE) begin
            tick_count_in = tick_count_ff + 16'd1;
            if (tick_count_in >= pt) begin
               if (phase_ff == PH_IDLELOW) begin
                  wiper_in = 7'd0;
                  do_final = 1'b1;
                  final_g  = 7'd0;
               end else if (sub_ff == SB_PREP) begin
                  sub_in        = SB_HIGH;
                  tick_count_in = 16'd0;
                  inc_high_in   = 1'b1;
               end else if (sub_ff == SB_HIGH && !cfg.rising_edge_only) begin
                  sub_in        = SB_LOW;
                  tick_count_in = 16'd0;
                  inc_high_in   = 1'b0;
               end else begin
                  // counted tap
                  if (mode_ff == MD_GOTO || mode_ff == MD_DELTA) begin
                     if (going_up_ff) begin
                        if (anchor_bottom_ff) begin
                           anchor_bottom_in = 1'b0;
                        end else begin
                           if (wiper_ff < TOP7) wiper_in = wiper_ff + 7'd1;
                           anchor_top_in = 1'b0;
                        end
                     end else begin
                        if (anchor_top_ff) begin
                           anchor_top_in = 1'b0;
                        end else begin
                           if (wiper_ff > 7'd0) wiper_in = wiper_ff - 7'd1;
                           anchor_bottom_in = 1'b0;
                        end
                     end
                  end
                  if (mode_ff == MD_GOTO) begin
                     if (wiper_in != goal_step_ff) begin
                        do_start   = 1'b1;
                        start_mode = MD_GOTO;
                     end else begin
                        do_final = 1'b1;
                        final_g  = goal_step_ff;
                     end
                  end else begin
                     t = (taps_left_ff > 9'd0) ? taps_left_ff - 9'd1 : taps_left_ff;
                     taps_left_in = t;
                     if (t > 9'd0) begin
                        do_start   = 1'b1;
                        start_mode = mode_ff;
                     end else if (mode_ff == MD_DELTA) begin
                        phase_in      = PH_IDLE;
                        tick_count_in = 16'd0;
                        finished      = 1'b1;
                     end else if (mode_ff == MD_RDOWN) begin
                        phase_in      = PH_IDLELOW;
                        tick_count_in = 16'd0;
                        inc_high_in   = 1'b0;
                     end else begin
                        anchor_top_in    = going_up_ff;
                        anchor_bottom_in = ~going_up_ff;
                        phase_in         = PH_IDLE;
                        tick_count_in    = 16'd0;
                        finished         = 1'b1;
                     end
                  end
               end
            end
         end
      end

      // arrival at a step: at an end step set the anchor or send extra taps, elsewhere clear the anchors
      if (do_final) begin
         if (final_g == 7'd0 || final_g == TOP7) begin
            going_up_in = (final_g != 7'd0);
            n = (final_g != 7'd0) ? cfg.extra_pulses_top : cfg.extra_pulses_bottom;
            if (n == 4'd0) begin
               anchor_top_in    = going_up_in;
               anchor_bottom_in = ~going_up_in;
               phase_in         = PH_IDLE;
               tick_count_in    = 16'd0;
               finished         = 1'b1;
            end else begin
               taps_left_in = 9'(n);
               do_start     = 1'b1;
               start_mode   = MD_EXTRA;
            end
         end else begin
            anchor_bottom_in = 1'b0;
            anchor_top_in    = 1'b0;
            phase_in         = PH_IDLE;
            tick_count_in    = 16'd0;
            finished         = 1'b1;
         end
      end

      if (do_start) begin
         phase_in      = PH_ACTIVE;
         mode_in       = start_mode;
         sub_in        = inc_high_in ? SB_PREP : SB_HIGH;
         tick_count_in = 16'd0;
         inc_high_in   = ~inc_high_in;
      end
   end

   always_comb begin
      case (phase_in)
         PH_IDLE: begin
            cs  = 1'b1;
            inc = inc_high_in;
         end
         PH_IDLELOW: begin
            cs  = 1'b1;
            inc = 1'b0;
         end
         default: begin
            case (sub_in)
               SB_PREP: begin
                  cs  = 1'b1;
                  inc = 1'b0;
               end
               SB_HIGH: begin
                  cs  = 1'b0;
                  inc = 1'b1;
               end
               default: begin
                  cs  = 1'b0;
                  inc = 1'b0;
               end
            endcase
         end
      endcase
   end

   assign result.chip_select_n    = cs;
   assign result.inc_level        = inc;
   assign result.up_down_level    = going_up_in ^ cfg.invert_direction;
   assign result.busy_res         = (phase_in != PH_IDLE);
   assign result.position         = wiper_in;
   assign result.at_bottom_anchor = anchor_bottom_in;
   assign result.at_top_anchor    = anchor_top_in;
   assign result.rejected         = rej;
   assign result.done_res         = finished;

   always_ff @(posedge clock) begin
      if (reset) begin
         wiper_ff         <= 7'd0;
         anchor_bottom_ff <= 1'b0;
         anchor_top_ff    <= 1'b0;
         inc_high_ff      <= 1'b0;
         taps_left_ff     <= 9'd0;
         phase_ff         <= PH_IDLE;
         mode_ff          <= MD_GOTO;
         sub_ff           <= SB_PREP;
         tick_count_ff    <= 16'd0;
         goal_step_ff     <= 7'd0;
         going_up_ff      <= 1'b0;
      end else if (step_en) begin
         wiper_ff         <= wiper_in;
         anchor_bottom_ff <= anchor_bottom_in;
         anchor_top_ff    <= anchor_top_in;
         inc_high_ff      <= inc_high_in;
         taps_left_ff     <= taps_left_in;
         phase_ff         <= phase_in;
         mode_ff          <= mode_in;
         sub_ff           <= sub_in;
         tick_count_ff    <= tick_count_in;
         goal_step_ff     <= goal_step_in;
         going_up_ff      <= going_up_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/digital_pot_step_controller.sv =====
// ----------------------------------------------------------------------------
// digital_pot_step_controller
// up/down digital potentiometer pin sequencer with wiper and anchor tracking
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    func, target, delta
//  rsp      out        rsp_valid/stall    pin levels, position, flags
//  csr      in         csr_we             csr_index, csr_wdata
//
//  one transaction per cycle sustained while rsp is not stalled; each passes
//  the input register, then the state update into the output register
//  every transaction is one tick or command and updates state once
//  reset clears state, handshake valids and the config register to their reset values
//  a stalled output holds; the input register takes one more transaction,
//  then req is stalled until the output drains
// ----------------------------------------------------------------------------
`default_nettype none

module digital_pot_step_controller #(
   parameter int TOP_STEP = 99
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire  [2:0]       req_func,
   input  wire  [6:0]       req_target,
   input  wire signed [8:0] req_delta,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output logic             rsp_chip_select_n,
   output logic             rsp_inc_level,
   output logic             rsp_up_down_level,
   output logic             rsp_busy_res,
   output logic [6:0]       rsp_position,
   output logic             rsp_at_bottom_anchor,
   output logic             rsp_at_top_anchor,
   output logic             rsp_rejected,
   output logic             rsp_done_res,
   input  wire              csr_we,
   input  wire  [2:0]       csr_index,
   input  wire  [15:0]      csr_wdata
);
   import dpsc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type result_ff, result_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PULSE_TICKS:  cfg_in.pulse_ticks         = csr_wdata;
            CSR_EXTRA_TOP:    cfg_in.extra_pulses_top    = csr_wdata[3:0];
            CSR_EXTRA_BOTTOM: cfg_in.extra_pulses_bottom = csr_wdata[3:0];
            CSR_INVERT_DIR:   cfg_in.invert_direction    = csr_wdata[0];
            CSR_RISING_ONLY:  cfg_in.rising_edge_only    = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign item_in = req_accept
                    ? item_type'{func: req_func, target: req_target, delta: req_delta}
                    : item_ff;
   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : ((out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff);

   dpsc_core #(
      .TOP_STEP(TOP_STEP)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .step_en(advance),
      .item   (item_ff),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{pulse_ticks: 16'd1, extra_pulses_top: 4'd0,
                           extra_pulses_bottom: 4'd0, invert_direction: 1'b0,
                           rising_edge_only: 1'b0};
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_chip_select_n    = result_ff.chip_select_n;
   assign rsp_inc_level        = result_ff.inc_level;
   assign rsp_up_down_level    = result_ff.up_down_level;
   assign rsp_busy_res         = result_ff.busy_res;
   assign rsp_position         = result_ff.position;
   assign rsp_at_bottom_anchor = result_ff.at_bottom_anchor;
   assign rsp_at_top_anchor    = result_ff.at_top_anchor;
   assign rsp_rejected         = result_ff.rejected;
   assign rsp_done_res         = result_ff.done_res;

endmodule

`default_nettype wire

// ===== hdl/dpsc_checker.sv =====
// ----------------------------------------------------------------------------
// dpsc_checker
// port-level properties of the digital pot step controller
// ----------------------------------------------------------------------------
`default_nettype none

`include "digital_pot_step_controller_macros.svh"

module dpsc_checker #(
   parameter int TOP_STEP = 99
) (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire       rsp_chip_select_n,
   input wire       rsp_busy_res,
   input wire [6:0] rsp_position,
   input wire       rsp_at_bottom_anchor,
   input wire       rsp_at_top_anchor,
   input wire       rsp_done_res
);

   `DPSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_position))
   `DPSC_ASSERT_SAME(a_idle_cs_high, clock, reset, rsp_valid && !rsp_busy_res, rsp_chip_select_n)
   `DPSC_ASSERT_SAME(a_one_anchor, clock, reset, rsp_valid, !(rsp_at_bottom_anchor && rsp_at_top_anchor))
   `DPSC_ASSERT_SAME(a_done_idle, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)
   `DPSC_ASSERT_SAME(a_pos_range, clock, reset, rsp_valid, rsp_position <= 7'(TOP_STEP))

endmodule

bind digital_pot_step_controller dpsc_checker #(.TOP_STEP(TOP_STEP)) u_dpsc_checker (.*);

`default_nettype wire
